// ===== rtl/core/gtmw_pkg.sv =====
package gtmw_pkg;

  // Item modes carried in the mode field of an input word.
  typedef enum logic [1:0] {
    MODE_LOAD        = 2'd0,
    MODE_DRAW_AT     = 2'd1,
    MODE_DRAW_CURSOR = 2'd2,
    MODE_UNUSED      = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_CHAR_BASE     = 3'd0;
  localparam cfg_index_t CFG_CHAR_COUNT    = 3'd1;
  localparam cfg_index_t CFG_CELL_WIDTH    = 3'd2;
  localparam cfg_index_t CFG_CELL_HEIGHT   = 3'd3;
  localparam cfg_index_t CFG_SHEET_COLUMNS = 3'd4;

  // Palette 2 in bits 15 to 12 of every map entry.
  localparam logic [15:0] MAP_PALETTE = 16'(2 << 12);

  localparam logic [6:0] CURSOR_MAX = 7'd127;

  // Divider request and response.
  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [6:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
    logic [6:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/core/gtmw_in_if.sv =====
interface gtmw_in_if;
  import gtmw_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] table_index;
  logic [7:0] table_value;
  logic [7:0] char_code;
  logic [6:0] tile_x;
  logic [5:0] tile_y;

  modport source (
    output valid, mode, table_index, table_value, char_code, tile_x, tile_y,
    input  ready
  );

  modport sink (
    input  valid, mode, table_index, table_value, char_code, tile_x, tile_y,
    output ready
  );

endinterface

// ===== rtl/core/gtmw_out_if.sv =====
interface gtmw_out_if;
  import gtmw_pkg::*;

  logic        valid;
  logic        ready;
  logic [9:0]  map_address;
  logic [15:0] map_entry;
  logic        last;

  modport source (
    output valid, map_address, map_entry, last,
    input  ready
  );

  modport sink (
    input  valid, map_address, map_entry, last,
    output ready
  );

endinterface

// ===== rtl/core/glyph_tile_map_writer.sv =====
// A load word is taken while idle. A draw word reads its table slot and starts the
// first divide, then runs the second divide and the start-tile multiply, and then
// gives one map write per cycle for each visible tile while the output is not stalled;
// no new word is taken until it is done. Both 8-step divides use the shared divider.
// Reset: the configuration registers return to their defaults and the cursor to zero.
// The glyph table is not cleared and holds nothing defined until it is loaded.
module glyph_tile_map_writer #(
  parameter int SCREEN_COLS       = 32,
  parameter int SCREEN_ROWS       = 24,
  parameter int GLYPH_TABLE_DEPTH = 256,
  parameter int MAX_CELL_SIDE     = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  gtmw_pkg::cfg_index_t   cfg_index,
  input  logic [8:0]             cfg_wdata,
  gtmw_in_if.sink                in_if,
  gtmw_out_if.source             out_if
);
  import gtmw_pkg::*;

  localparam int AW = $clog2(GLYPH_TABLE_DEPTH);
  localparam logic [7:0]  COLS8     = 8'(SCREEN_COLS);
  localparam logic [6:0]  ROWS7     = 7'(SCREEN_ROWS);
  localparam logic [9:0]  COLS10    = 10'(SCREEN_COLS);
  localparam logic [8:0]  DEPTH9    = 9'(GLYPH_TABLE_DEPTH);
  localparam logic [3:0]  MAX_SIDE4 = 4'(MAX_CELL_SIDE);

  // The sequencer walks one draw word through both divides, the start-tile multiply
  // and then the tile emission. Only the idle state takes new words.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV1 = 6'b000010,
    S_DIV2 = 6'b000100,
    S_MUL1 = 6'b001000,
    S_MUL2 = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [7:0] char_base_r;
  logic [8:0] char_count_r;
  logic [3:0] cell_width_r;
  logic [3:0] cell_height_r;
  logic [6:0] sheet_columns_r;

  // Cursor.
  logic [6:0] cursor_col_r, cursor_col_nxt;
  logic [5:0] cursor_row_r, cursor_row_nxt;

  // Working registers of the current draw word.
  logic [6:0] col_r, col_nxt;
  logic [5:0] row_r, row_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [6:0] rem_r, rem_nxt;
  logic [9:0] t1_r, t1_nxt;
  logic [9:0] t2_r, t2_nxt;
  logic [3:0] vw_r, vw_nxt;
  logic [3:0] vh_r, vh_nxt;
  logic [2:0] c_cnt_r, c_cnt_nxt;
  logic [2:0] r_cnt_r, r_cnt_nxt;
  logic [9:0] tile_row_r, tile_row_nxt;
  logic [9:0] addr_row_r, addr_row_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  out_addr_r, out_addr_nxt;
  logic [15:0] out_entry_r, out_entry_nxt;
  logic        out_last_r, out_last_nxt;

  // Glyph memory and divider hookup.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  // Decoded input word.
  logic       in_acc;
  mode_t      in_mode;
  logic       is_draw;
  logic [6:0] col_sel;
  logic [5:0] row_sel;
  logic [7:0] slot;
  logic       char_ok;
  logic [7:0] adv_sum;

  // Clamped cell sides.
  logic [3:0] wc;
  logic [3:0] hc;

  // Visible-area and emission helpers.
  logic [7:0] col_room;
  logic [6:0] row_room;
  logic [3:0] vw_calc;
  logic [3:0] vh_calc;
  logic [9:0] start_tile;
  logic [9:0] addr_base;
  logic       out_free;
  logic       word_last;
  logic       row_end;
  logic [9:0] tile_now;

  assign in_acc  = in_if.valid && in_if.ready;
  assign in_mode = mode_t'(in_if.mode);
  assign is_draw = (in_mode == MODE_DRAW_AT) || (in_mode == MODE_DRAW_CURSOR);

  assign wc = (cell_width_r > MAX_SIDE4) ? MAX_SIDE4 : cell_width_r;
  assign hc = (cell_height_r > MAX_SIDE4) ? MAX_SIDE4 : cell_height_r;

  // Mode 1 moves the cursor before drawing; mode 2 draws where the cursor stands.
  assign col_sel = (in_mode == MODE_DRAW_AT) ? in_if.tile_x : cursor_col_r;
  assign row_sel = (in_mode == MODE_DRAW_AT) ? in_if.tile_y : cursor_row_r;
  assign adv_sum = {1'b0, col_sel} + {4'b0, wc};

  // A character is drawn only when it falls inside the loaded range of the table and
  // the cell has a nonzero size.
  assign slot    = in_if.char_code - char_base_r;
  assign char_ok = (in_if.char_code >= char_base_r) &&
                   ({1'b0, slot} < char_count_r) &&
                   ({1'b0, slot} < DEPTH9) &&
                   (wc != 4'd0) && (hc != 4'd0);

  assign mem_we    = in_acc && (in_mode == MODE_LOAD) && ({1'b0, in_if.table_index} < DEPTH9);
  assign mem_waddr = in_if.table_index[AW-1:0];
  assign mem_re    = in_acc && is_draw && char_ok;
  assign mem_raddr = slot[AW-1:0];

  // The first divide gives cells per sheet row, the second splits the cell number
  // into sheet row and sheet column. The table read has finished long before.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, sheet_columns_r};
    div_req.divisor  = {3'b0, wc};
    if (mem_re) begin
      div_req.start = 1'b1;
    end else if ((state_r == S_DIV1) && div_rsp.done && (div_rsp.quotient != 8'd0)) begin
      div_req.start    = 1'b1;
      div_req.dividend = mem_rdata;
      div_req.divisor  = div_rsp.quotient[6:0];
    end
  end

  // Visible part of the cell: tiles at or past the screen edge are never visited.
  assign col_room = COLS8 - {1'b0, col_r};
  assign row_room = ROWS7 - {1'b0, row_r};
  assign vw_calc  = ({1'b0, col_r} >= COLS8) ? 4'd0 :
                    (col_room < {4'b0, wc}) ? col_room[3:0] : wc;
  assign vh_calc  = ({1'b0, row_r} >= ROWS7) ? 4'd0 :
                    (row_room < {3'b0, hc}) ? row_room[3:0] : hc;

  // Start tile in the sheet and first map address, both modulo 1024.
  assign start_tile = t1_r * {3'b0, sheet_columns_r} + t2_r;
  assign addr_base  = {4'b0, row_r} * COLS10 + {3'b0, col_r};

  assign out_free  = !out_valid_r || out_if.ready;
  assign row_end   = ({1'b0, c_cnt_r} == vw_r - 4'd1);
  assign word_last = row_end && ({1'b0, r_cnt_r} == vh_r - 4'd1);
  assign tile_now  = tile_row_r + {7'b0, c_cnt_r};

  always_comb begin
    state_nxt      = state_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    t1_nxt         = t1_r;
    t2_nxt         = t2_r;
    vw_nxt         = vw_r;
    vh_nxt         = vh_r;
    c_cnt_nxt      = c_cnt_r;
    r_cnt_nxt      = r_cnt_r;
    tile_row_nxt   = tile_row_r;
    addr_row_nxt   = addr_row_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_entry_nxt  = out_entry_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && is_draw) begin
          // The cursor advances whether or not the character draws anything.
          col_nxt        = col_sel;
          row_nxt        = row_sel;
          cursor_row_nxt = row_sel;
          cursor_col_nxt = (adv_sum > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : adv_sum[6:0];
          if (char_ok) begin
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          // A cell wider than the sheet leaves no cell per row and draws nothing.
          state_nxt = (div_rsp.quotient == 8'd0) ? S_IDLE : S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          quo_nxt   = div_rsp.quotient;
          rem_nxt   = div_rsp.remainder;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        t1_nxt    = {2'b0, quo_r} * {6'b0, hc};
        t2_nxt    = {3'b0, rem_r} * {6'b0, wc};
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        vw_nxt       = vw_calc;
        vh_nxt       = vh_calc;
        c_cnt_nxt    = '0;
        r_cnt_nxt    = '0;
        tile_row_nxt = start_tile;
        addr_row_nxt = addr_base;
        state_nxt    = ((vw_calc == 4'd0) || (vh_calc == 4'd0)) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = addr_row_r + {7'b0, c_cnt_r};
          out_entry_nxt = MAP_PALETTE | {6'b0, tile_now};
          out_last_nxt  = word_last;
          if (row_end) begin
            c_cnt_nxt    = '0;
            r_cnt_nxt    = r_cnt_r + 3'd1;
            tile_row_nxt = tile_row_r + {3'b0, sheet_columns_r};
            addr_row_nxt = addr_row_r + COLS10;
          end else begin
            c_cnt_nxt = c_cnt_r + 3'd1;
          end
          if (word_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      cursor_col_r    <= '0;
      cursor_row_r    <= '0;
      char_base_r     <= 8'd32;
      char_count_r    <= 9'd96;
      cell_width_r    <= 4'd1;
      cell_height_r   <= 4'd1;
      sheet_columns_r <= 7'd32;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHAR_BASE:     char_base_r     <= cfg_wdata[7:0];
          CFG_CHAR_COUNT:    char_count_r    <= cfg_wdata;
          CFG_CELL_WIDTH:    cell_width_r    <= cfg_wdata[3:0];
          CFG_CELL_HEIGHT:   cell_height_r   <= cfg_wdata[3:0];
          CFG_SHEET_COLUMNS: sheet_columns_r <= cfg_wdata[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    t1_r        <= t1_nxt;
    t2_r        <= t2_nxt;
    vw_r        <= vw_nxt;
    vh_r        <= vh_nxt;
    c_cnt_r     <= c_cnt_nxt;
    r_cnt_r     <= r_cnt_nxt;
    tile_row_r  <= tile_row_nxt;
    addr_row_r  <= addr_row_nxt;
    out_addr_r  <= out_addr_nxt;
    out_entry_r <= out_entry_nxt;
    out_last_r  <= out_last_nxt;
  end

  gtmw_glyph_ram #(
    .DEPTH (GLYPH_TABLE_DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_if.table_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gtmw_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.map_address = out_addr_r;
  assign out_if.map_entry   = out_entry_r;
  assign out_if.last        = out_last_r;

`ifndef NO_ASSERTIONS
  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == S_DIV1) || (state_r == S_DIV2)))
    else $error("divider finished outside a divide state");

  // Emission only runs over a nonempty visible area.
  a_emit_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> ((vw_r != 4'd0) && (vh_r != 4'd0)))
    else $error("emission started on an empty area");

  // The row and column counters stay inside the visible area.
  a_emit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (({1'b0, r_cnt_r} < vh_r) && ({1'b0, c_cnt_r} < vw_r)))
    else $error("tile counters left the visible area");

  // A word with last set ends the draw, so the sequencer is idle right after it loads.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && out_free && word_last) |=> (state_r == S_IDLE))
    else $error("draw continued after its last word");
`endif

endmodule

// ===== rtl/core/gtmw_glyph_ram.sv =====
module gtmw_glyph_ram #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/gtmw_divider.sv =====
module gtmw_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  gtmw_pkg::div_req_t req,
  output gtmw_pkg::div_rsp_t rsp
);
  import gtmw_pkg::*;

  localparam int STEPS = 8;

  logic       busy_r;
  logic       done_r;
  logic [2:0] cnt_r;
  logic [7:0] quo_r;
  logic [6:0] rem_r;
  logic [6:0] divisor_r;

  logic [7:0] trial;
  logic [7:0] diff;
  logic       fits;

  // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
  assign trial = {rem_r, quo_r[7]};
  assign diff  = trial - {1'b0, divisor_r};
  assign fits  = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[6:0], fits};
      rem_r <= fits ? diff[6:0] : trial[6:0];
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
